>>> src/fed_pkg.sv
// ----------------------------------------------------------------------------
// fed_pkg: shared types and constants for the feedback echo delay
// Sample and gain widths, register indexes, reset values and payload structs.
// ----------------------------------------------------------------------------
package fed_pkg;

	localparam int unsigned SAMPLE_BITS   = 16;
	localparam int unsigned GAIN_W        = 15;
	localparam int unsigned FRAC_BITS     = 15;
	localparam int unsigned CFG_W         = 15;
	localparam int unsigned CFG_ADDR_W    = 2;
	localparam int unsigned MAX_DELAY_DEF = 16384;

	localparam logic [CFG_W-1:0] DELAY_LEN_RST     = 15'd9600;
	localparam logic [CFG_W-1:0] INPUT_GAIN_RST    = 15'd19661;
	localparam logic [CFG_W-1:0] FEEDBACK_GAIN_RST = 15'd16384;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_DELAY_LEN     = 2'd0,
		REG_INPUT_GAIN    = 2'd1,
		REG_FEEDBACK_GAIN = 2'd2
	} fed_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] in_sample;
		logic                          flush;
		logic                          start_req;
	} fed_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_sample;
		logic                          clipped;
	} fed_out_t;

endpackage

>>> src/fed_ram.sv
// ----------------------------------------------------------------------------
// fed_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read and a read enable.
// ----------------------------------------------------------------------------
module fed_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/fed_addr.sv
// ----------------------------------------------------------------------------
// fed_addr: delay line position and fill tracking
// Picks the slot for each accepted request and advances the wrap position.
// ----------------------------------------------------------------------------
module fed_addr #(
	parameter int unsigned MAX_DELAY = fed_pkg::MAX_DELAY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         acc,
	input  logic                         start,
	input  logic [fed_pkg::CFG_W-1:0]    delay_len,
	output logic [$clog2(MAX_DELAY)-1:0] slot,
	output logic                         use_fb
);
	import fed_pkg::*;

	localparam int unsigned AW     = $clog2(MAX_DELAY);
	localparam int unsigned LEN_NB = $clog2(MAX_DELAY + 1);
	localparam int unsigned LEN_W  = (LEN_NB > CFG_W) ? LEN_NB : CFG_W;

	logic [AW-1:0]    position_q;
	logic             filled_q;
	logic [LEN_W-1:0] len_raw;
	logic [LEN_W-1:0] len_eff;
	logic [LEN_W-1:0] pos_inc;
	logic             wrap;

	// A zero length acts as one; anything past the memory acts as the full depth.
	always_comb begin
		len_raw = LEN_W'(delay_len);
		if (len_raw == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_raw > LEN_W'(MAX_DELAY)) begin
			len_eff = LEN_W'(MAX_DELAY);
		end else begin
			len_eff = len_raw;
		end
	end

	assign slot    = start ? '0 : position_q;
	assign use_fb  = start ? 1'b0 : filled_q;
	assign pos_inc = LEN_W'(slot) + LEN_W'(1);
	assign wrap    = (pos_inc >= len_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			filled_q   <= 1'b0;
		end else if (acc) begin
			if (wrap) begin
				position_q <= '0;
				filled_q   <= 1'b1;
			end else begin
				position_q <= pos_inc[AW-1:0];
				filled_q   <= use_fb;
			end
		end
	end

`ifndef SYNTHESIS
	a_start_clears_fill: assert property (@(posedge clk) disable iff (!arst_n)
		acc && start && (len_eff > LEN_W'(1)) |=> !filled_q && (position_q == AW'(1)))
		else $error("start request did not restart the delay line");
`endif

endmodule

>>> src/fed_mix.sv
// ----------------------------------------------------------------------------
// fed_mix: gain, feedback add, rounding and saturation
// Forms x*input_gain + d*feedback_gain in Q.15, rounds half up and clips.
// ----------------------------------------------------------------------------
module fed_mix (
	input  logic signed [fed_pkg::SAMPLE_BITS-1:0] x,
	input  logic signed [fed_pkg::SAMPLE_BITS-1:0] d,
	input  logic                                   use_fb,
	input  logic        [fed_pkg::GAIN_W-1:0]      in_gain,
	input  logic        [fed_pkg::GAIN_W-1:0]      fb_gain,
	output fed_pkg::fed_out_t                      res
);
	import fed_pkg::*;

	localparam int unsigned ACC_W = SAMPLE_BITS + GAIN_W + 2;
	localparam int unsigned Q_W   = ACC_W - FRAC_BITS;
	localparam logic signed [Q_W-1:0] QMAX = Q_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [Q_W-1:0] QMIN = Q_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));

	logic signed [GAIN_W:0]    ig_s;
	logic signed [GAIN_W:0]    fg_s;
	logic signed [ACC_W-1:0]   p_in;
	logic signed [ACC_W-1:0]   p_fb;
	logic signed [ACC_W-1:0]   acc_sum;
	logic signed [Q_W-1:0]     q;

	assign ig_s = {1'b0, in_gain};
	assign fg_s = {1'b0, fb_gain};
	assign p_in = ACC_W'(x) * ACC_W'(ig_s);
	assign p_fb = use_fb ? ACC_W'(d) * ACC_W'(fg_s) : '0;
	assign acc_sum = p_in + p_fb + HALF;

	// Arithmetic shift gives the floor, so halves round toward plus infinity.
	assign q = Q_W'(acc_sum >>> FRAC_BITS);

	always_comb begin
		if (q > QMAX) begin
			res.out_sample = QMAX[SAMPLE_BITS-1:0];
			res.clipped    = 1'b1;
		end else if (q < QMIN) begin
			res.out_sample = QMIN[SAMPLE_BITS-1:0];
			res.clipped    = 1'b1;
		end else begin
			res.out_sample = q[SAMPLE_BITS-1:0];
			res.clipped    = 1'b0;
		end
	end

endmodule

>>> src/feedback_echo_delay.sv
// Pipeline: a request is registered in stage one, its result in the output register,
// and a stall on the output holds both. Throughput: one sample per cycle unless stalled;
// each sample does one read-modify-write of the delay RAM, with the previous sample's
// write forwarded when both hit one slot.
// Reset: position, fill state and pipeline valids clear and the registers take their
// defaults; RAM is not cleared. Users must read a slot only once written (not enforced).
// ----------------------------------------------------------------------------
// feedback_echo_delay: recirculating echo top level
// Input gain plus scaled delayed sample, saturated and fed back to the delay line.
// ----------------------------------------------------------------------------
module feedback_echo_delay #(
	parameter int unsigned MAX_DELAY = fed_pkg::MAX_DELAY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           samp_valid,
	output logic                           samp_stall,
	input  fed_pkg::fed_in_t               samp,
	output logic                           echo_valid,
	input  logic                           echo_stall,
	output fed_pkg::fed_out_t              echo,
	input  logic                           cfg_we,
	input  logic [fed_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [fed_pkg::CFG_W-1:0]      cfg_wdata
);
	import fed_pkg::*;

	localparam int unsigned AW = $clog2(MAX_DELAY);

	logic [CFG_W-1:0] delay_len_q;
	logic [GAIN_W-1:0] input_gain_q;
	logic [GAIN_W-1:0] feedback_gain_q;

	logic                          samp_acc;
	logic                          s1_adv;
	logic [AW-1:0]                 rd_slot;
	logic                          rd_use_fb;

	logic                          s1_valid_q;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic                          use_fb_s1;
	logic [AW-1:0]                 slot_s1;
	logic                          fwd_s1;
	logic signed [SAMPLE_BITS-1:0] fwd_data_s1;

	logic [SAMPLE_BITS-1:0]        ram_rdata;
	logic signed [SAMPLE_BITS-1:0] dly;
	fed_out_t                      mix_res;

	logic                          echo_valid_q;
	fed_out_t                      echo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_len_q     <= DELAY_LEN_RST;
			input_gain_q    <= INPUT_GAIN_RST;
			feedback_gain_q <= FEEDBACK_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_DELAY_LEN:     delay_len_q     <= cfg_wdata;
				REG_INPUT_GAIN:    input_gain_q    <= cfg_wdata;
				REG_FEEDBACK_GAIN: feedback_gain_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign s1_adv     = s1_valid_q && (!echo_valid_q || !echo_stall);
	assign samp_stall = s1_valid_q && !s1_adv;
	assign samp_acc   = samp_valid && !samp_stall;

	fed_addr #(
		.MAX_DELAY(MAX_DELAY)
	) u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (samp_acc),
		.start    (samp.start_req),
		.delay_len(delay_len_q),
		.slot     (rd_slot),
		.use_fb   (rd_use_fb)
	);

	fed_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_DELAY)
	) u_ram (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(slot_s1),
		.wdata(mix_res.out_sample),
		.re   (samp_acc),
		.raddr(rd_slot),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (samp_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// When the sample leaving stage one writes the slot that the new sample reads,
	// the RAM still returns the old word, so the written value is captured instead.
	always_ff @(posedge clk) begin
		if (samp_acc) begin
			x_s1        <= samp.flush ? '0 : samp.in_sample;
			use_fb_s1   <= rd_use_fb;
			slot_s1     <= rd_slot;
			fwd_s1      <= s1_adv && (rd_slot == slot_s1);
			fwd_data_s1 <= mix_res.out_sample;
		end
	end

	assign dly = fwd_s1 ? fwd_data_s1 : $signed(ram_rdata);

	fed_mix u_mix (
		.x      (x_s1),
		.d      (dly),
		.use_fb (use_fb_s1),
		.in_gain(input_gain_q),
		.fb_gain(feedback_gain_q),
		.res    (mix_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_valid_q <= 1'b0;
		end else if (s1_adv) begin
			echo_valid_q <= 1'b1;
		end else if (!echo_stall) begin
			echo_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			echo_q <= mix_res;
		end
	end

	assign echo_valid = echo_valid_q;
	assign echo       = echo_q;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		samp_stall |-> s1_valid_q && echo_valid_q && echo_stall)
		else $error("input stalled while the pipeline had room");

	a_adv_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> echo_valid_q)
		else $error("stage one advanced but no result was held");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		samp_acc |=> s1_valid_q)
		else $error("accepted request was lost before stage one");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		echo_valid_q && echo_stall |=> echo_valid_q && $stable(echo_q))
		else $error("held result was overwritten");
`endif

endmodule

>>> sim/tb_feedback_echo_delay.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_feedback_echo_delay: self-checking bench for the recirculating echo
// A queue-fed driver sends sample requests and a clocked monitor checks every
// echo against a local model of the gain, feedback, rounding and saturation.
// ----------------------------------------------------------------------------
module tb_feedback_echo_delay;
	import fed_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam longint SMAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint SMIN = -SMAX - 1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  samp_valid = 1'b0;
	logic                  samp_stall;
	fed_in_t               samp = '0;
	logic                  echo_valid;
	logic                  echo_stall = 1'b0;
	fed_out_t              echo;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;

	// Local copy of the register file and the delay line.
	logic [CFG_W-1:0]              dly_len_sh = DELAY_LEN_RST;
	logic [CFG_W-1:0]              in_gain_sh = INPUT_GAIN_RST;
	logic [CFG_W-1:0]              fb_gain_sh = FEEDBACK_GAIN_RST;
	logic signed [SAMPLE_BITS-1:0] line_mem [MAX_DELAY_DEF];
	int unsigned                   line_pos = 0;
	bit                            line_full = 1'b0;

	fed_in_t  sample_q [$];
	fed_out_t expected_echoes [$];
	fed_in_t  next_req;
	fed_out_t echo_want;
	int       pending_cnt = 0;
	int       mismatch_cnt = 0;
	int       cycle_cnt = 0;
	bit       restart_due = 1'b0;
	logic     calm;

	feedback_echo_delay DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.samp_valid (samp_valid),
		.samp_stall (samp_stall),
		.samp       (samp),
		.echo_valid (echo_valid),
		.echo_stall (echo_stall),
		.echo       (echo),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// In calm stretches the driver never idles and the output never stalls.
	assign calm = (cycle_cnt % 5000) >= 4000;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int unsigned eff_delay(input logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DELAY_DEF)
			return MAX_DELAY_DEF;
		return v;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_cnt++;
		if (mismatch_cnt <= 40)
			$display("%0t: mismatch: %s", $time, what);
	endtask

	// Works out the echo for one accepted request and advances the delay line.
	task automatic compute_echo(input fed_in_t r);
		int unsigned len;
		longint      acc;
		longint      q;
		fed_out_t    e;
		len = eff_delay(dly_len_sh);
		if (r.start_req) begin
			line_pos = 0;
			line_full = 1'b0;
		end
		acc = r.flush ? 0 : longint'($signed(r.in_sample)) * longint'(in_gain_sh);
		if (line_full)
			acc += longint'($signed(line_mem[line_pos])) * longint'(fb_gain_sh);
		// Adding one half and shifting rounds halves toward plus infinity.
		q = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
		e.clipped = 1'b0;
		if (q > SMAX) begin
			q = SMAX;
			e.clipped = 1'b1;
		end else if (q < SMIN) begin
			q = SMIN;
			e.clipped = 1'b1;
		end
		e.out_sample = q[SAMPLE_BITS-1:0];
		line_mem[line_pos] = q[SAMPLE_BITS-1:0];
		if (line_pos + 1 >= len) begin
			line_pos = 0;
			line_full = 1'b1;
		end else begin
			line_pos++;
		end
		expected_echoes.push_back(e);
	endtask

	task automatic push_item(input logic [SAMPLE_BITS-1:0] s, input logic fl, input logic st);
		fed_in_t r;
		// After the delay grows, a restart keeps reads inside slots already written.
		if (restart_due) begin
			st = 1'b1;
			restart_due = 1'b0;
		end
		r.in_sample = s;
		r.flush = fl;
		r.start_req = st;
		pending_cnt++;
		sample_q.push_back(r);
	endtask

	task automatic write_reg(input fed_reg_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DELAY_LEN: begin
				if (eff_delay(val) > eff_delay(dly_len_sh))
					restart_due = 1'b1;
				dly_len_sh = val;
			end
			REG_INPUT_GAIN: in_gain_sh = val;
			REG_FEEDBACK_GAIN: fb_gain_sh = val;
			default: ;
		endcase
	endtask

	task automatic wait_quiet();
		while (pending_cnt != 0 || expected_echoes.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 15'd16384;
			default: return CFG_W'($urandom());
		endcase
	endfunction

	// Request driver: the model advances on every accepted request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (samp_valid && !samp_stall) begin
				compute_echo(samp);
				pending_cnt--;
			end
			if (!samp_valid || !samp_stall) begin
				if (sample_q.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
					next_req = sample_q.pop_front();
					samp <= next_req;
					samp_valid <= 1'b1;
				end else begin
					samp_valid <= 1'b0;
				end
			end
		end
	end

	// Echo monitor.
	always @(posedge clk) begin
		if (arst_n && echo_valid && !echo_stall) begin
			if (expected_echoes.size() == 0) begin
				report_mismatch("echo with no request pending");
			end else begin
				echo_want = expected_echoes.pop_front();
				if (echo.out_sample !== echo_want.out_sample)
					report_mismatch($sformatf("out_sample %0d, expected %0d",
						$signed(echo.out_sample), $signed(echo_want.out_sample)));
				if (echo.clipped !== echo_want.clipped)
					report_mismatch($sformatf("clipped %b, expected %b",
						echo.clipped, echo_want.clipped));
			end
		end
		echo_stall <= !calm && ($urandom_range(0, 99) < 28);
	end

	initial begin
		logic [CFG_W-1:0]       dl;
		logic [SAMPLE_BITS-1:0] smp;
		int unsigned            flush_left;
		flush_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset gains: full-scale samples and rounding of plus and minus one.
		push_item(16'h7fff, 1'b0, 1'b0);
		push_item(16'h8000, 1'b0, 1'b0);
		push_item(16'h0000, 1'b0, 1'b0);
		push_item(16'h0001, 1'b0, 1'b0);
		push_item(16'hffff, 1'b0, 1'b0);
		push_item(16'h3039, 1'b1, 1'b0);
		wait_quiet();

		// Short delay at full gains: feedback saturates both ways, then the tail drains.
		write_reg(REG_DELAY_LEN, 15'd3);
		write_reg(REG_INPUT_GAIN, '1);
		write_reg(REG_FEEDBACK_GAIN, '1);
		push_item(16'h7fff, 1'b0, 1'b1);
		push_item(16'h8000, 1'b0, 1'b0);
		push_item(16'h4000, 1'b0, 1'b0);
		push_item(16'h7fff, 1'b0, 1'b0);
		push_item(16'h8000, 1'b0, 1'b0);
		push_item(16'h0000, 1'b1, 1'b0);
		push_item(16'h1234, 1'b1, 1'b0);
		wait_quiet();

		// Delay of zero acts as one, shortened while running; half gains hit exact halves.
		write_reg(REG_DELAY_LEN, '0);
		write_reg(REG_INPUT_GAIN, 15'd16384);
		write_reg(REG_FEEDBACK_GAIN, 15'd16384);
		push_item(16'h0001, 1'b0, 1'b0);
		push_item(16'hffff, 1'b0, 1'b0);
		push_item(16'h0001, 1'b0, 1'b0);
		push_item(16'hfffd, 1'b0, 1'b0);
		push_item(16'h0000, 1'b1, 1'b0);
		wait_quiet();

		// Delay above the line size acts as the full line; the line stays unfilled.
		write_reg(REG_DELAY_LEN, '1);
		write_reg(REG_INPUT_GAIN, INPUT_GAIN_RST);
		write_reg(REG_FEEDBACK_GAIN, 15'd24000);
		for (int k = 0; k < 60; k++)
			push_item(SAMPLE_BITS'($urandom()), k >= 50, 1'b0);
		wait_quiet();

		// Random phases, mostly short delays so the feedback path is busy.
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0 || $urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: dl = '0;
					1: dl = CFG_W'($urandom_range(200, 2000));
					default: dl = CFG_W'($urandom_range(1, 24));
				endcase
				write_reg(REG_DELAY_LEN, dl);
			end
			write_reg(REG_INPUT_GAIN, pick_gain());
			write_reg(REG_FEEDBACK_GAIN, pick_gain());
			for (int k = 0; k < 60; k++) begin
				if (flush_left == 0 && $urandom_range(0, 19) == 0)
					flush_left = $urandom_range(2, 24);
				if ($urandom_range(0, 7) == 0)
					smp = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
				else
					smp = SAMPLE_BITS'($urandom());
				push_item(smp, flush_left != 0, $urandom_range(0, 39) == 0);
				if (flush_left != 0)
					flush_left--;
			end
			wait_quiet();
		end

		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> files.f
src/fed_pkg.sv
src/fed_ram.sv
src/fed_addr.sv
src/fed_mix.sv
src/feedback_echo_delay.sv
sim/tb_feedback_echo_delay.sv
